[hw/rtl/dma_register_and_irq_unit_defines.svh]
// ----------------------------------------------------------------------------
// dma register and irq unit assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef DMA_REGISTER_AND_IRQ_UNIT_DEFINES_SVH
`define DMA_REGISTER_AND_IRQ_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// checked at every rising edge while reset is released
`define DMAIRQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define DMAIRQ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DMAIRQ_ASSERT(name, clk, rst_n, prop, msg)
`define DMAIRQ_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

[hw/rtl/dmairq_pkg.sv]
// ----------------------------------------------------------------------------
// dmairq_pkg
// shared constants, types and field packing helpers of the dma register unit
// ----------------------------------------------------------------------------
`default_nettype none

package dmairq_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IRQ_W        = 7;

    localparam logic [31:0] DPCR_RESET = 32'h0765_4321;
    localparam logic [6:0]  DPCR_OFS   = 7'h70;
    localparam logic [6:0]  DICR_OFS   = 7'h74;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [1:0] {
        OP_READ_WORD  = 2'd0,
        OP_WRITE_WORD = 2'd1,
        OP_WRITE_BYTE = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        REG_BASE    = 4'h0,
        REG_BLOCK   = 4'h4,
        REG_CONTROL = 4'h8
    } t_chan_reg;

    typedef enum logic [1:0] {
        SYNC_MANUAL   = 2'd0,
        SYNC_REQUEST  = 2'd1,
        SYNC_LINKED   = 2'd2,
        SYNC_RESERVED = 2'd3
    } t_sync_mode;

    typedef enum logic [1:0] {
        DICR_BYTE_LOW     = 2'd0,
        DICR_BYTE_FORCE   = 2'd1,
        DICR_BYTE_ENABLE  = 2'd2,
        DICR_BYTE_PENDING = 2'd3
    } t_dicr_byte;

    // stored channel control, compact form
    typedef struct packed {
        logic       trigger;
        logic       start;
        logic [2:0] chop_cpu;
        logic [2:0] chop_dma;
        logic [1:0] sync;
        logic       chop;
        logic       decrement;
        logic       from_ram;
    } t_chan_ctrl;

    function automatic t_chan_ctrl ctrl_pack(input logic [31:0] v);
        t_chan_ctrl c;
        c.from_ram  = v[0];
        c.decrement = v[1];
        c.chop      = v[8];
        c.sync      = v[10:9];
        c.chop_dma  = v[18:16];
        c.chop_cpu  = v[22:20];
        c.start     = v[24];
        c.trigger   = v[28];
        return c;
    endfunction

    function automatic logic [31:0] ctrl_value(input t_chan_ctrl c);
        logic [31:0] v;
        v        = '0;
        v[0]     = c.from_ram;
        v[1]     = c.decrement;
        v[8]     = c.chop;
        v[10:9]  = c.sync;
        v[18:16] = c.chop_dma;
        v[22:20] = c.chop_cpu;
        v[24]    = c.start;
        v[28]    = c.trigger;
        return v;
    endfunction

    function automatic logic master_calc(
        input logic             force_irq,
        input logic             master_en,
        input logic [IRQ_W-1:0] mask,
        input logic [IRQ_W-1:0] pending
    );
        return force_irq | (master_en & (|(mask & pending)));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dma_register_and_irq_unit.sv]
// ----------------------------------------------------------------------------
// dma_register_and_irq_unit
// register file and interrupt logic of a seven-channel dma controller
// ----------------------------------------------------------------------------
// Usage: one bus access per s_axis transaction: tuser carries the opcode
// (read word, write word, byte write into DICR), tdata the byte offset and
// the write value. Each access yields exactly one m_axis transaction with
// read data, a bad offset flag, the interrupt rise flag and, for a control
// write that starts a channel, the transfer command fields.
// Each access passes the input register, then the result register.
// Throughput: one access per cycle while m_axis_tready is high; the
// decode, register update and 16x16 word count multiply sit between the
// input register and the result register.
// Reset: DPCR loads 0x07654321, DICR and all channel registers clear, both
// stages empty.
// Stall: when m_axis_tready is low the result holds, one more access waits
// in the input register, and s_axis_tready drops only once both are full.
// Register state changes as an access moves into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dma_register_and_irq_unit_defines.svh"

module dma_register_and_irq_unit
    import dmairq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [6:0] offset, [38:7] write_data, [39] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]             s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] read_data, [32] bad_offset, [33] irq_raise, [34] xfer_start,
    // [37:35] xfer_channel, [61:38] xfer_base, [93:62] xfer_words,
    // [94] xfer_from_ram, [95] xfer_decrement, [97:96] xfer_mode, [103:98] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    // input stage
    logic        r_in_valid;
    t_opcode     r_in_op;
    logic [6:0]  r_in_offset;
    logic [31:0] r_in_wdata;

    // result stage
    logic        r_out_valid;
    logic [31:0] r_read_data;
    logic        r_bad_offset;
    logic        r_irq_raise;
    logic        r_xfer_start;
    logic [2:0]  r_xfer_channel;
    logic [23:0] r_xfer_base;
    logic [31:0] r_xfer_words;
    logic        r_xfer_from_ram;
    logic        r_xfer_decrement;
    logic [1:0]  r_xfer_mode;

    // register file
    logic [31:0]      r_prio;
    logic             r_force;
    logic [IRQ_W-1:0] r_mask;
    logic             r_men;
    logic [IRQ_W-1:0] r_pend;
    logic             r_master;
    logic [23:0]      r_base  [NUM_CHANNELS];
    logic [15:0]      r_size  [NUM_CHANNELS];
    logic [15:0]      r_count [NUM_CHANNELS];
    t_chan_ctrl       r_ctrl  [NUM_CHANNELS];

    logic [31:0]      n_prio;
    logic             n_force;
    logic [IRQ_W-1:0] n_mask;
    logic             n_men;
    logic [IRQ_W-1:0] n_pend;
    logic             n_master;
    logic [23:0]      n_base  [NUM_CHANNELS];
    logic [15:0]      n_size  [NUM_CHANNELS];
    logic [15:0]      n_count [NUM_CHANNELS];
    t_chan_ctrl       n_ctrl  [NUM_CHANNELS];

    logic [31:0] n_read_data;
    logic        n_bad_offset;
    logic        n_irq_raise;
    logic        n_xfer_start;
    logic [2:0]  n_xfer_channel;
    logic [23:0] n_xfer_base;
    logic [31:0] n_xfer_words;
    logic        n_xfer_from_ram;
    logic        n_xfer_decrement;
    logic [1:0]  n_xfer_mode;

    logic            advance;
    logic [2:0]      w_ch;
    logic [CH_W-1:0] w_idx;
    logic [3:0]      w_reg;
    logic            w_ch_ok;
    logic [31:0]     w_prod;
    t_chan_ctrl      w_new_ctrl;
    logic            w_go;
    logic [7:0]      w_byte;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign w_ch    = r_in_offset[6:4];
    assign w_idx   = w_ch[CH_W-1:0];
    assign w_reg   = r_in_offset[3:0];
    assign w_ch_ok = (32'(w_ch) < NUM_CHANNELS) &&
                     (w_reg == REG_BASE || w_reg == REG_BLOCK || w_reg == REG_CONTROL);
    assign w_prod  = 32'(r_size[w_idx]) * 32'(r_count[w_idx]);
    assign w_new_ctrl = ctrl_pack(r_in_wdata);
    // manual mode needs trigger as well as start
    assign w_go    = w_new_ctrl.start &&
                     (w_new_ctrl.sync != SYNC_MANUAL || w_new_ctrl.trigger);
    assign w_byte  = r_in_wdata[7:0];

    always_comb begin
        n_prio  = r_prio;
        n_force = r_force;
        n_mask  = r_mask;
        n_men   = r_men;
        n_pend  = r_pend;
        n_master = r_master;
        n_base  = r_base;
        n_size  = r_size;
        n_count = r_count;
        n_ctrl  = r_ctrl;

        n_read_data      = '0;
        n_bad_offset     = 1'b0;
        n_irq_raise      = 1'b0;
        n_xfer_start     = 1'b0;
        n_xfer_channel   = '0;
        n_xfer_base      = '0;
        n_xfer_words     = '0;
        n_xfer_from_ram  = 1'b0;
        n_xfer_decrement = 1'b0;
        n_xfer_mode      = '0;

        unique case (r_in_op)
            OP_READ_WORD: begin
                if (r_in_offset == DPCR_OFS) begin
                    n_read_data = r_prio;
                end else if (r_in_offset == DICR_OFS) begin
                    n_read_data = {r_master, r_pend, r_men, r_mask, r_force, 15'd0};
                end else if (w_ch_ok) begin
                    unique case (w_reg)
                        REG_BASE:  n_read_data = {8'd0, r_base[w_idx]};
                        REG_BLOCK: n_read_data = {r_count[w_idx], r_size[w_idx]};
                        default:   n_read_data = ctrl_value(r_ctrl[w_idx]);
                    endcase
                end else begin
                    n_bad_offset = 1'b1;
                end
            end
            OP_WRITE_WORD: begin
                if (r_in_offset == DPCR_OFS) begin
                    n_prio = r_in_wdata;
                end else if (r_in_offset == DICR_OFS) begin
                    n_force     = r_in_wdata[15];
                    n_mask      = r_in_wdata[22:16];
                    n_men       = r_in_wdata[23];
                    n_pend      = r_pend & ~r_in_wdata[30:24];
                    n_master    = master_calc(n_force, n_men, n_mask, n_pend);
                    n_irq_raise = !r_master && n_master;
                end else if (w_ch_ok) begin
                    unique case (w_reg)
                        REG_BASE: begin
                            n_base[w_idx] = r_in_wdata[23:0];
                        end
                        REG_BLOCK: begin
                            n_size[w_idx]  = r_in_wdata[15:0];
                            n_count[w_idx] = r_in_wdata[31:16];
                        end
                        default: begin
                            n_ctrl[w_idx] = w_new_ctrl;
                            if (w_go) begin
                                n_xfer_start     = 1'b1;
                                n_xfer_channel   = w_ch;
                                n_xfer_base      = r_base[w_idx];
                                n_xfer_from_ram  = w_new_ctrl.from_ram;
                                n_xfer_decrement = w_new_ctrl.decrement;
                                n_xfer_mode      = w_new_ctrl.sync;
                                unique case (w_new_ctrl.sync)
                                    SYNC_MANUAL:  n_xfer_words = {16'd0, r_size[w_idx]};
                                    SYNC_REQUEST: n_xfer_words = w_prod;
                                    default:      n_xfer_words = '0;
                                endcase
                                // transfer completes at once
                                n_ctrl[w_idx].start   = 1'b0;
                                n_ctrl[w_idx].trigger = 1'b0;
                                if (r_mask[w_ch]) begin
                                    n_pend      = r_pend | (IRQ_W'(1) << w_ch);
                                    n_master    = master_calc(r_force, r_men, r_mask, n_pend);
                                    n_irq_raise = !r_master && n_master;
                                end
                            end
                        end
                    endcase
                end else begin
                    n_bad_offset = 1'b1;
                end
            end
            OP_WRITE_BYTE: begin
                // master flag is left as is on byte writes
                unique case (t_dicr_byte'(r_in_offset[1:0]))
                    DICR_BYTE_FORCE: begin
                        n_force = w_byte[7];
                    end
                    DICR_BYTE_ENABLE: begin
                        n_mask = w_byte[6:0];
                        n_men  = w_byte[7];
                    end
                    DICR_BYTE_PENDING: begin
                        n_pend = r_pend & ~w_byte[6:0];
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prio      <= DPCR_RESET;
            r_force     <= 1'b0;
            r_mask      <= '0;
            r_men       <= 1'b0;
            r_pend      <= '0;
            r_master    <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_base[i]  <= '0;
                r_size[i]  <= '0;
                r_count[i] <= '0;
                r_ctrl[i]  <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_prio      <= n_prio;
                r_force     <= n_force;
                r_mask      <= n_mask;
                r_men       <= n_men;
                r_pend      <= n_pend;
                r_master    <= n_master;
                r_base      <= n_base;
                r_size      <= n_size;
                r_count     <= n_count;
                r_ctrl      <= n_ctrl;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op     <= t_opcode'(s_axis_tuser);
            r_in_offset <= s_axis_tdata[6:0];
            r_in_wdata  <= s_axis_tdata[38:7];
        end
        if (advance) begin
            r_read_data      <= n_read_data;
            r_bad_offset     <= n_bad_offset;
            r_irq_raise      <= n_irq_raise;
            r_xfer_start     <= n_xfer_start;
            r_xfer_channel   <= n_xfer_channel;
            r_xfer_base      <= n_xfer_base;
            r_xfer_words     <= n_xfer_words;
            r_xfer_from_ram  <= n_xfer_from_ram;
            r_xfer_decrement <= n_xfer_decrement;
            r_xfer_mode      <= n_xfer_mode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_xfer_mode, r_xfer_decrement, r_xfer_from_ram,
                            r_xfer_words, r_xfer_base, r_xfer_channel, r_xfer_start,
                            r_irq_raise, r_bad_offset, r_read_data};

    // a rising master flag always goes out with irq_raise set
    `DMAIRQ_ASSERT(a_master_rise_reported, i_clk, i_rst_n,
        $rose(r_master) |-> (r_out_valid && r_irq_raise), "master flag rose unreported")

    // a waiting access is neither lost nor altered
    `DMAIRQ_ASSERT(a_input_held, i_clk, i_rst_n,
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_offset) && $stable(r_in_wdata)),
        "waiting access lost")

    // transfers come only from handled control word writes
    `DMAIRQ_ASSERT(a_xfer_from_write, i_clk, i_rst_n,
        (advance && n_xfer_start) |-> (r_in_op == OP_WRITE_WORD && !n_bad_offset &&
                                       w_reg == REG_CONTROL),
        "transfer issued by a non control write")

    // state only changes while an access is committed
    `DMAIRQ_ASSERT(a_state_quiet, i_clk, i_rst_n,
        !$past(advance) |-> ($stable(r_pend) && $stable(r_master) && $stable(r_prio)),
        "register state changed without an access")

endmodule

`default_nettype wire
